### rtl/ssi_pkg.sv
// ----------------------------------------------------------------------------
// ssi_pkg
// Shared constants for the segment intersection pipeline.
// ----------------------------------------------------------------------------
package ssi_pkg;

    localparam int COORD_WIDTH_DEF = 16;

    // stages ahead of the divider: deltas, products, cross, normalize, multiply
    localparam int PRE_STAGES = 5;

endpackage

### rtl/segment_segment_intersection_unit.sv
// ----------------------------------------------------------------------------
// segment_segment_intersection_unit
// Pipelined fixed-point segment/segment intersection with exact hit test.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive the eight endpoint coordinates with start high; the
//   transfer happens at a rising edge with start high and busy low. busy is
//   always low, so a new pair can be given on every cycle.
//   Result channel: done is high for exactly one cycle with hit, cross_x and
//   cross_y; the result is taken at the edge that ends that cycle. When hit
//   is low, cross_x and cross_y are zero.
//   Throughput: one pair per cycle. Depth is set by the restoring divider,
//   which resolves one quotient bit per stage for COORD_WIDTH stages, after
//   five stages of deltas, products, cross products, sign normalization and
//   the offset multiply. An output register follows the last divider stage.
//   Reset clears all valid bits; no result comes out until a new transfer.
//   The receiver cannot stall, so no back-pressure path exists. Coordinates
//   share one fixed-point scale, which does not enter the computation.
// ----------------------------------------------------------------------------
module segment_segment_intersection_unit #(
    parameter int COORD_WIDTH = ssi_pkg::COORD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] a_start_x,
    input  logic signed [COORD_WIDTH-1:0] a_start_y,
    input  logic signed [COORD_WIDTH-1:0] a_end_x,
    input  logic signed [COORD_WIDTH-1:0] a_end_y,
    input  logic signed [COORD_WIDTH-1:0] b_start_x,
    input  logic signed [COORD_WIDTH-1:0] b_start_y,
    input  logic signed [COORD_WIDTH-1:0] b_end_x,
    input  logic signed [COORD_WIDTH-1:0] b_end_y,
    output logic                          done,
    output logic                          hit,
    output logic signed [COORD_WIDTH-1:0] cross_x,
    output logic signed [COORD_WIDTH-1:0] cross_y
);
    import ssi_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int PW = 2 * W + 2;   // product of two deltas
    localparam int CW = 2 * W + 3;   // cross product
    localparam int DW = 2 * W + 1;   // magnitude of the denominator
    localparam int NW = 3 * W + 1;   // dividend t_num * |dir|
    localparam int LATENCY = PRE_STAGES + W + 1;

    typedef struct packed {
        logic         hit;
        logic         neg_x;
        logic         neg_y;
        logic [W-1:0] px;
        logic [W-1:0] py;
    } side_t;

    logic accept;

    // stage 1: deltas
    logic                v1_reg;
    logic signed [W:0]   rx1_reg, ry1_reg, sx1_reg, sy1_reg, dx1_reg, dy1_reg;
    logic [W-1:0]        px1_reg, py1_reg;

    // stage 2: products
    logic                v2_reg;
    logic signed [PW-1:0] prs_reg, psr_reg, pds_reg, psd_reg, pdr_reg, prd_reg;
    logic signed [W:0]   rx2_reg, ry2_reg;
    logic [W-1:0]        px2_reg, py2_reg;

    // stage 3: cross products
    logic                v3_reg;
    logic signed [CW-1:0] den3_reg, ts3_reg, us3_reg;
    logic signed [W:0]   rx3_reg, ry3_reg;
    logic [W-1:0]        px3_reg, py3_reg;

    // stage 4: sign normalization
    logic                v4_reg;
    logic                zero4_reg;
    logic [DW-1:0]       den4_reg;
    logic signed [CW-1:0] ts4_reg, us4_reg;
    logic [W-1:0]        mx4_reg, my4_reg;
    logic                negx4_reg, negy4_reg;
    logic [W-1:0]        px4_reg, py4_reg;

    logic                den_neg;
    logic signed [CW-1:0] ts_norm_next, us_norm_next;
    logic [DW-1:0]       den_abs_next;
    logic [W-1:0]        mx_next, my_next;

    // stage 5 and divider stages
    logic                hit_next;
    logic [NW-1:0]       nx_next, ny_next;
    logic                vd_reg   [0:W];
    logic [DW-1:0]       remx_reg [0:W];
    logic [DW-1:0]       remy_reg [0:W];
    logic [W-1:0]        shx_reg  [0:W];
    logic [W-1:0]        shy_reg  [0:W];
    logic [DW-1:0]       dend_reg [0:W];
    side_t               side_reg [0:W];

    // output
    logic                done_reg;
    logic                hit_reg;
    logic [W-1:0]        cx_reg, cy_reg;
    logic [W-1:0]        cx_next, cy_next;
    side_t               side_last;
    logic [W-1:0]        qx_last, qy_last;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // ---------------- valid chain ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            vd_reg[0] <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            v1_reg    <= accept;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            vd_reg[0] <= v4_reg;
            done_reg  <= vd_reg[W];
        end
    end

    // ---------------- stages 1 to 3 ----------------
    always_ff @(posedge clk)
    begin
        rx1_reg <= (W+1)'(a_end_x) - (W+1)'(a_start_x);
        ry1_reg <= (W+1)'(a_end_y) - (W+1)'(a_start_y);
        sx1_reg <= (W+1)'(b_end_x) - (W+1)'(b_start_x);
        sy1_reg <= (W+1)'(b_end_y) - (W+1)'(b_start_y);
        dx1_reg <= (W+1)'(b_start_x) - (W+1)'(a_start_x);
        dy1_reg <= (W+1)'(b_start_y) - (W+1)'(a_start_y);
        px1_reg <= a_start_x;
        py1_reg <= a_start_y;

        prs_reg <= PW'(rx1_reg) * PW'(sy1_reg);
        psr_reg <= PW'(ry1_reg) * PW'(sx1_reg);
        pds_reg <= PW'(dx1_reg) * PW'(sy1_reg);
        psd_reg <= PW'(dy1_reg) * PW'(sx1_reg);
        pdr_reg <= PW'(dx1_reg) * PW'(ry1_reg);
        prd_reg <= PW'(dy1_reg) * PW'(rx1_reg);
        rx2_reg <= rx1_reg;
        ry2_reg <= ry1_reg;
        px2_reg <= px1_reg;
        py2_reg <= py1_reg;

        den3_reg <= CW'(prs_reg) - CW'(psr_reg);
        ts3_reg  <= CW'(pds_reg) - CW'(psd_reg);
        us3_reg  <= CW'(pdr_reg) - CW'(prd_reg);
        rx3_reg  <= rx2_reg;
        ry3_reg  <= ry2_reg;
        px3_reg  <= px2_reg;
        py3_reg  <= py2_reg;
    end

    // ---------------- stage 4 ----------------
    always_comb
    begin
        den_neg      = den3_reg[CW-1];
        den_abs_next = den_neg ? DW'(-den3_reg) : DW'(den3_reg);
        ts_norm_next = den_neg ? -ts3_reg : ts3_reg;
        us_norm_next = den_neg ? -us3_reg : us3_reg;
        mx_next      = rx3_reg[W] ? W'(-rx3_reg) : W'(rx3_reg);
        my_next      = ry3_reg[W] ? W'(-ry3_reg) : W'(ry3_reg);
    end

    always_ff @(posedge clk)
    begin
        zero4_reg <= (den3_reg == '0);
        den4_reg  <= den_abs_next;
        ts4_reg   <= ts_norm_next;
        us4_reg   <= us_norm_next;
        mx4_reg   <= mx_next;
        my4_reg   <= my_next;
        negx4_reg <= rx3_reg[W];
        negy4_reg <= ry3_reg[W];
        px4_reg   <= px3_reg;
        py4_reg   <= py3_reg;
    end

    // ---------------- stage 5: hit test and offset products ----------------
    always_comb
    begin
        hit_next = !zero4_reg && !ts4_reg[CW-1] && !us4_reg[CW-1]
                   && ($unsigned(ts4_reg) <= CW'(den4_reg))
                   && ($unsigned(us4_reg) <= CW'(den4_reg));
        nx_next  = NW'(ts4_reg[DW-1:0]) * NW'(mx4_reg);
        ny_next  = NW'(ts4_reg[DW-1:0]) * NW'(my4_reg);
    end

    always_ff @(posedge clk)
    begin
        remx_reg[0]       <= nx_next[NW-1:W];
        shx_reg[0]        <= nx_next[W-1:0];
        remy_reg[0]       <= ny_next[NW-1:W];
        shy_reg[0]        <= ny_next[W-1:0];
        dend_reg[0]       <= den4_reg;
        side_reg[0].hit   <= hit_next;
        side_reg[0].neg_x <= negx4_reg;
        side_reg[0].neg_y <= negy4_reg;
        side_reg[0].px    <= px4_reg;
        side_reg[0].py    <= py4_reg;
    end

    // ---------------- divider: one quotient bit per stage ----------------
    // Quotient is below 2^W on a hit, so the upper dividend bits seed the
    // remainder directly. Quotient bits shift into the low end of sh.
    for (genvar k = 0; k < W; k++)
    begin : g_div
        logic [DW:0] trial_x, trial_y;
        logic        ge_x, ge_y;

        assign trial_x = {remx_reg[k], shx_reg[k][W-1]};
        assign trial_y = {remy_reg[k], shy_reg[k][W-1]};
        assign ge_x    = trial_x >= {1'b0, dend_reg[k]};
        assign ge_y    = trial_y >= {1'b0, dend_reg[k]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vd_reg[k+1] <= 1'b0;
            end
            else
            begin
                vd_reg[k+1] <= vd_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            remx_reg[k+1] <= ge_x ? DW'(trial_x - {1'b0, dend_reg[k]}) : DW'(trial_x);
            remy_reg[k+1] <= ge_y ? DW'(trial_y - {1'b0, dend_reg[k]}) : DW'(trial_y);
            shx_reg[k+1]  <= {shx_reg[k][W-2:0], ge_x};
            shy_reg[k+1]  <= {shy_reg[k][W-2:0], ge_y};
            dend_reg[k+1] <= dend_reg[k];
            side_reg[k+1] <= side_reg[k];
        end
    end

    // ---------------- output ----------------
    always_comb
    begin
        side_last = side_reg[W];
        qx_last   = shx_reg[W];
        qy_last   = shy_reg[W];
        if (side_last.hit)
        begin
            cx_next = side_last.neg_x ? side_last.px - qx_last : side_last.px + qx_last;
            cy_next = side_last.neg_y ? side_last.py - qy_last : side_last.py + qy_last;
        end
        else
        begin
            cx_next = '0;
            cy_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg <= side_last.hit;
        cx_reg  <= cx_next;
        cy_reg  <= cy_next;
    end

    assign done    = done_reg;
    assign hit     = hit_reg;
    assign cross_x = cx_reg;
    assign cross_y = cy_reg;

`ifndef SYNTHESIS
    a_latency_fwd : assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("transfer did not produce a result after the pipeline latency");

    a_latency_bwd : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("result strobe without a matching input transfer");

    a_nohit_zero : assert property (@(posedge clk) disable iff (!rst_n)
        done && !hit |-> (cross_x == '0) && (cross_y == '0))
        else $error("nonzero point reported without a hit");
`endif

endmodule
